@@ src/pls_pkg.sv @@
// Shared types and codes for the positional list store.
package pls_pkg;

  localparam int unsigned OP_W    = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
  localparam logic [OP_W-1:0] OP_DEL_END   = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_READ      = 4'd6;
  localparam logic [OP_W-1:0] OP_TRAVERSE  = 4'd7;
  localparam logic [OP_W-1:0] OP_REVERSE   = 4'd8;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRAV,
    ST_REV
  } state_t;

  typedef enum logic [1:0] {
    CK_HOLD,
    CK_INS,
    CK_DEL,
    CK_ROT
  } chain_op_t;

  // Per-cell load selects; at most one is set in any cycle.
  typedef struct packed {
    logic take_left;
    logic take_right;
    logic take_new;
    logic take_front;
  } cell_ctl_t;

endpackage

@@ src/positional_list_store.sv @@
// Top level of the positional list store: control, status checks and the cell chain.
//
// Usage. A command beat is taken on a rising edge where start is high and
// busy is low; it carries in_op, in_position and in_value. Each result beat
// appears on out_status, out_value_res and out_last for exactly one cycle,
// marked by out_valid, and the receiver must take it then.
// Inserts, deletes and reads give their result in the cycle after the
// command, and busy stays low, so a new command may follow every cycle.
// Traverse holds busy while it gives one beat per cycle, front to back,
// by rotating the occupied cells left through the front cell. Reverse
// holds busy while it rotates a shrinking prefix, one rotation per cycle,
// then gives one beat. The chain of cells shifts all cells in parallel.
// Empty, range and full errors, and unused op codes, give one beat in the
// next cycle with no change to the list.
// Reset (rst_n low, synchronous) empties the list, returns to idle and
// drops out_valid; the cell contents are not cleared and are never read
// before being written.
module positional_list_store
  import pls_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_op,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [VAL_W-1:0]  out_value_res,
  output logic                     out_last
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = ((LW > POS_W) ? LW : POS_W) + 1;

  // Control state.
  state_t          state_r, state_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [IW-1:0]   k_r, k_nxt;

  // Result register.
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_res_r, out_value_res_nxt;
  logic                    out_last_r, out_last_nxt;

  // Chain command for this cycle.
  chain_op_t     chain_op;
  logic [IW-1:0] chain_idx;

  logic signed [VAL_W-1:0] cell_val [DEPTH];
  cell_ctl_t               cell_ctl [DEPTH];
  logic signed [VAL_W-1:0] rd_val;

  logic          accept;
  logic          is_empty;
  logic          is_full;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] len_c;
  logic          ins_pos_ok;
  logic          acc_pos_ok;
  logic [IW-1:0] pos_idx;
  logic [IW-1:0] len_m1;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign is_empty   = (len_r == '0);
  assign is_full    = (len_r == LW'(DEPTH));
  assign pos_c      = CW'(in_position);
  assign len_c      = CW'(len_r);
  assign ins_pos_ok = (pos_c != '0) && (pos_c <= len_c + CW'(1));
  assign acc_pos_ok = (pos_c != '0) && (pos_c <= len_c);
  assign pos_idx    = IW'(pos_c - CW'(1));
  assign len_m1     = IW'(len_r - LW'(1));

  // Read port: each cell is gated by its own index match and the results are ORed.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_idx == IW'(i)) begin
        rd_val = rd_val | cell_val[i];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_empty) begin
          if (in_op == OP_TRAVERSE) begin
            state_nxt = ST_TRAV;
            k_nxt     = len_m1;
          end else if (in_op == OP_REVERSE && len_r != LW'(1)) begin
            state_nxt = ST_REV;
            k_nxt     = len_m1;
          end
        end
      end
      ST_TRAV: begin
        k_nxt = k_r - IW'(1);
        if (k_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REV: begin
        k_nxt = k_r - IW'(1);
        if (k_r == IW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs: chain command, length update and the result beat.
  always_comb begin
    chain_op          = CK_HOLD;
    chain_idx         = '0;
    len_nxt           = len_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = STAT_OK;
    out_value_res_nxt = '0;
    out_last_nxt      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_op)
            OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
              if (in_op == OP_INS_AT && !ins_pos_ok) begin
                out_status_nxt = STAT_RANGE;
              end else if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                chain_op = CK_INS;
                if (in_op == OP_INS_FRONT) begin
                  chain_idx = '0;
                end else if (in_op == OP_INS_END) begin
                  chain_idx = IW'(len_r);
                end else begin
                  chain_idx = pos_idx;
                end
                len_nxt = len_r + LW'(1);
              end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else if (in_op == OP_DEL_AT && !acc_pos_ok) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                // Dropping the back cell only needs the count to shrink.
                if (in_op == OP_DEL_FRONT) begin
                  chain_op = CK_DEL;
                end else if (in_op == OP_DEL_AT) begin
                  chain_op  = CK_DEL;
                  chain_idx = pos_idx;
                end
                len_nxt = len_r - LW'(1);
              end
            end
            OP_READ: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else if (!acc_pos_ok) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                out_value_res_nxt = rd_val;
              end
            end
            OP_TRAVERSE, OP_REVERSE: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else if (in_op == OP_TRAVERSE || len_r != LW'(1)) begin
                // The beats come from the multi-cycle states.
                out_valid_nxt = 1'b0;
              end
            end
            default: begin
              out_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      ST_TRAV: begin
        // The front cell goes out and wraps around to the back of the list.
        chain_op          = CK_ROT;
        chain_idx         = len_m1;
        out_valid_nxt     = 1'b1;
        out_value_res_nxt = cell_val[0];
        out_last_nxt      = (k_r == '0);
      end
      ST_REV: begin
        // Move the front value to index k, shrinking k each cycle.
        chain_op  = CK_ROT;
        chain_idx = k_r;
        if (k_r == IW'(1)) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        chain_op = CK_HOLD;
      end
    endcase
  end

  // Per-cell load selects derived from the chain command.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i] = '0;
      case (chain_op)
        CK_INS: begin
          cell_ctl[i].take_left = (IW'(i) > chain_idx);
          cell_ctl[i].take_new  = (IW'(i) == chain_idx);
        end
        CK_DEL: begin
          cell_ctl[i].take_right = (IW'(i) >= chain_idx);
        end
        CK_ROT: begin
          cell_ctl[i].take_right = (IW'(i) < chain_idx);
          cell_ctl[i].take_front = (IW'(i) == chain_idx);
        end
        default: begin
          cell_ctl[i] = '0;
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    pls_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .left_val  (left_v),
      .right_val (right_v),
      .new_val   (in_value),
      .front_val (cell_val[0]),
      .val       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r    <= out_status_nxt;
    out_value_res_r <= out_value_res_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_res = out_value_res_r;
  assign out_last      = out_last_r;

endmodule

@@ src/pls_cell.sv @@
// One storage cell of the list chain, loading from a neighbor, the new value or the front.
module pls_cell
  import pls_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic signed [VAL_W-1:0] new_val,
  input  logic signed [VAL_W-1:0] front_val,
  output logic signed [VAL_W-1:0] val
);

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.take_left) begin
      val_nxt = left_val;
    end else if (ctl.take_right) begin
      val_nxt = right_val;
    end else if (ctl.take_new) begin
      val_nxt = new_val;
    end else if (ctl.take_front) begin
      val_nxt = front_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
